[hw/rtl/mts_pkg.sv]
package mts_pkg;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ATTACH = 3'd1;
  localparam logic [2:0] MODE_DETACH = 3'd2;
  localparam logic [2:0] MODE_CHANGE = 3'd3;
  localparam logic [2:0] MODE_SYNC   = 3'd4;
  localparam logic [2:0] MODE_FIRE   = 3'd5;
  localparam logic [2:0] MODE_QUERY  = 3'd6;

  localparam int FIRE_CAP = 64;
  localparam logic [15:0] JITTER_RESET = 16'd1000;

  typedef enum logic [2:0] {
    OP_TICK, OP_ATTACH, OP_DETACH, OP_CHANGE, OP_SYNC, OP_FIRE, OP_QUERY
  } op_t;

  // one queued word, already classified by the front
  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [2:0]  tidx;
    logic [2:0]  ridx;
    logic [15:0] dly;
    logic        per;
    logic [15:0] adv;
  } word_t;

endpackage

[hw/rtl/mts_ram.sv]
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[hw/rtl/mts_front.sv]
module mts_front #(
  parameter int NUM_TIMERS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_mode,
  input  logic [2:0]        in_timer_index,
  input  logic [2:0]        in_reference_index,
  input  logic [15:0]       in_delay,
  input  logic              in_periodic,
  input  logic [15:0]       in_advance,
  input  logic              pop,
  output logic              q_valid,
  output mts_pkg::word_t    q_word
);

  mts_pkg::word_t w;
  mts_pkg::word_t ent_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     fill_r;
  logic           push;

  always_comb begin
    w.tidx = in_timer_index;
    w.ridx = in_reference_index;
    w.dly  = in_delay;
    w.per  = in_periodic;
    w.adv  = in_advance;
    w.bad  = (32'(in_timer_index) >= NUM_TIMERS);
    case (in_mode)
      mts_pkg::MODE_TICK:   w.op = mts_pkg::OP_TICK;
      mts_pkg::MODE_ATTACH: w.op = mts_pkg::OP_ATTACH;
      mts_pkg::MODE_DETACH: w.op = mts_pkg::OP_DETACH;
      mts_pkg::MODE_CHANGE: w.op = mts_pkg::OP_CHANGE;
      mts_pkg::MODE_SYNC: begin
        w.op  = mts_pkg::OP_SYNC;
        w.bad = (32'(in_timer_index) >= NUM_TIMERS) ||
                (32'(in_reference_index) >= NUM_TIMERS);
      end
      mts_pkg::MODE_FIRE:   w.op = mts_pkg::OP_FIRE;
      mts_pkg::MODE_QUERY:  w.op = mts_pkg::OP_QUERY;
      default:              w.op = mts_pkg::OP_QUERY;
    endcase
  end

  assign busy    = (fill_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill_r != 2'd0);
  assign q_word  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

[hw/rtl/mts_back.sv]
module mts_back #(
  parameter int NUM_TIMERS   = 8,
  parameter int COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       jitter,
  input  logic              q_valid,
  input  mts_pkg::word_t    q_word,
  output logic              pop,
  output logic              out_strobe,
  output logic              out_fired,
  output logic [2:0]        out_fired_index,
  output logic [15:0]       out_remaining,
  output logic              out_was_running,
  output logic              out_last
);

  localparam int CW  = COUNTER_BITS;
  localparam int IW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int DW  = CW + 16;
  localparam int DCW = $clog2(CW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_FLUSH, S_OP_RD, S_OP_EV,
    S_REF_RD, S_REF_EV, S_DIV, S_SYNC_WR
  } state_t;

  state_t                 state_r;
  mts_pkg::word_t         cur_r;
  logic [CW-1:0]          cnt_r;
  logic [NUM_TIMERS-1:0]  active_r;
  logic [NUM_TIMERS-1:0]  rep_r;
  logic [NUM_TIMERS-1:0]  wrt_r;

  logic [IW-1:0]          scan_idx_r;
  logic                   found_r;
  logic [IW-1:0]          best_r;
  logic [CW-1:0]          best_late_r;
  logic [CW-1:0]          best_tgt_r;
  logic [15:0]            best_dly_r;
  logic [6:0]             fires_r;
  logic                   pend_v_r;
  logic [IW-1:0]          pend_idx_r;
  logic [15:0]            pend_rem_r;

  logic [CW-1:0]          div_dvd_r;
  logic [15:0]            div_rem_r;
  logic [DCW-1:0]         div_cnt_r;

  logic                   wr_en_r;
  logic [IW-1:0]          wr_addr_r;
  logic [DW-1:0]          wr_data_r;

  logic                   byp_r;
  logic [DW-1:0]          byp_data_r;

  logic                   out_v_r;
  logic                   out_fired_r;
  logic [2:0]             out_idx_r;
  logic [15:0]            out_rem_r;
  logic                   out_was_r;
  logic                   out_last_r;

  logic [IW-1:0]          t_i;
  logic [IW-1:0]          r_i;
  logic [IW-1:0]          rd_addr;
  logic [IW-1:0]          ev_idx;
  logic [DW-1:0]          rd_data;
  logic [DW-1:0]          rd_word;
  logic [CW-1:0]          rd_tgt;
  logic [15:0]            rd_dly;
  logic [CW-1:0]          late;
  logic                   take;
  logic                   sel_found;
  logic [IW-1:0]          sel_best;
  logic [CW-1:0]          sel_tgt;
  logic [15:0]            sel_dly;
  logic [CW-1:0]          fire_tgt;
  logic                   was;
  logic [CW-1:0]          left;
  logic [CW-1:0]          elapsed;
  logic                   chg_fire;
  logic [CW-1:0]          chg_tgt;
  logic [16:0]            trial;
  logic [15:0]            incr;

  mts_ram #(.WIDTH(DW), .DEPTH(NUM_TIMERS)) u_ram (
    .clk   (clk),
    .we    (wr_en_r),
    .waddr (wr_addr_r),
    .wdata (wr_data_r),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign t_i = IW'(cur_r.tidx);
  assign r_i = IW'(cur_r.ridx);
  assign pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    case (state_r)
      S_SCAN_RD: rd_addr = scan_idx_r;
      S_REF_RD:  rd_addr = r_i;
      default:   rd_addr = t_i;
    endcase
    case (state_r)
      S_SCAN_EV: ev_idx = scan_idx_r;
      S_REF_EV:  ev_idx = r_i;
      default:   ev_idx = t_i;
    endcase
  end

  // a write landing on the edge of a read forwards its data
  always_ff @(posedge clk) begin
    byp_r      <= wr_en_r && (wr_addr_r == rd_addr);
    byp_data_r <= wr_data_r;
  end

  assign rd_word = byp_r ? byp_data_r : rd_data;

  // entries never written read as zero
  assign rd_tgt = wrt_r[ev_idx] ? rd_word[DW-1:16] : '0;
  assign rd_dly = wrt_r[ev_idx] ? rd_word[15:0] : '0;

  assign late      = cnt_r - rd_tgt;
  assign take      = active_r[ev_idx] && (32'(late) < 32'(jitter)) &&
                     (!found_r || (late > best_late_r));
  assign sel_found = found_r || take;
  assign sel_best  = take ? scan_idx_r : best_r;
  assign sel_tgt   = take ? rd_tgt : best_tgt_r;
  assign sel_dly   = take ? rd_dly : best_dly_r;
  assign fire_tgt  = sel_tgt + CW'(sel_dly);

  assign was      = active_r[t_i];
  assign left     = was ? (rd_tgt - cnt_r) : '0;
  assign elapsed  = CW'(rd_dly) - left;
  assign chg_fire = (32'(elapsed) > 32'(cur_r.dly));
  assign chg_tgt  = chg_fire ? (cnt_r + CW'(cur_r.dly))
                             : (rd_tgt + CW'(cur_r.dly) - CW'(rd_dly));

  // restoring remainder step, one dividend bit per cycle
  assign trial = {div_rem_r, div_dvd_r[CW-1]};
  assign incr  = cur_r.dly - div_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      active_r <= '0;
      rep_r    <= '0;
      wrt_r    <= '0;
      pend_v_r <= 1'b0;
      wr_en_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      out_v_r <= 1'b0;
      wr_en_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_word;
            if (q_word.op == mts_pkg::OP_TICK) begin
              cnt_r      <= cnt_r + CW'(q_word.adv);
              scan_idx_r <= '0;
              found_r    <= 1'b0;
              fires_r    <= '0;
              pend_v_r   <= 1'b0;
              state_r    <= S_SCAN_RD;
            end else if (q_word.bad) begin
              out_v_r     <= 1'b1;
              out_fired_r <= 1'b0;
              out_idx_r   <= q_word.tidx;
              out_rem_r   <= '0;
              out_was_r   <= 1'b0;
              out_last_r  <= 1'b1;
            end else begin
              state_r <= S_OP_RD;
            end
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_EV;
        S_SCAN_EV: begin
          found_r     <= sel_found;
          best_r      <= sel_best;
          best_late_r <= take ? late : best_late_r;
          best_tgt_r  <= sel_tgt;
          best_dly_r  <= sel_dly;
          if (scan_idx_r == IW'(NUM_TIMERS - 1)) begin
            if (sel_found) begin
              // previous fire goes out now, this one waits to learn if it is last
              if (pend_v_r) begin
                out_v_r     <= 1'b1;
                out_fired_r <= 1'b1;
                out_idx_r   <= 3'(pend_idx_r);
                out_rem_r   <= pend_rem_r;
                out_was_r   <= 1'b1;
                out_last_r  <= 1'b0;
              end
              pend_v_r   <= 1'b1;
              pend_idx_r <= sel_best;
              if (rep_r[sel_best]) begin
                wr_en_r          <= 1'b1;
                wr_addr_r        <= sel_best;
                wr_data_r        <= {fire_tgt, sel_dly};
                wrt_r[sel_best]  <= 1'b1;
                pend_rem_r       <= 16'(fire_tgt - cnt_r);
              end else begin
                active_r[sel_best] <= 1'b0;
                pend_rem_r         <= '0;
              end
              fires_r    <= fires_r + 7'd1;
              found_r    <= 1'b0;
              scan_idx_r <= '0;
              state_r    <= (fires_r == 7'(mts_pkg::FIRE_CAP - 1)) ? S_FLUSH : S_SCAN_RD;
            end else begin
              out_v_r     <= 1'b1;
              out_fired_r <= pend_v_r;
              out_idx_r   <= pend_v_r ? 3'(pend_idx_r) : 3'd0;
              out_rem_r   <= pend_v_r ? pend_rem_r : 16'd0;
              out_was_r   <= pend_v_r;
              out_last_r  <= 1'b1;
              pend_v_r    <= 1'b0;
              state_r     <= S_IDLE;
            end
          end else begin
            scan_idx_r <= scan_idx_r + IW'(1);
            state_r    <= S_SCAN_RD;
          end
        end
        S_FLUSH: begin
          out_v_r     <= 1'b1;
          out_fired_r <= 1'b1;
          out_idx_r   <= 3'(pend_idx_r);
          out_rem_r   <= pend_rem_r;
          out_was_r   <= 1'b1;
          out_last_r  <= 1'b1;
          pend_v_r    <= 1'b0;
          state_r     <= S_IDLE;
        end
        S_OP_RD: state_r <= S_OP_EV;
        S_OP_EV: begin
          out_v_r     <= 1'b1;
          out_fired_r <= 1'b0;
          out_idx_r   <= cur_r.tidx;
          out_rem_r   <= 16'(left);
          out_was_r   <= was;
          out_last_r  <= 1'b1;
          state_r     <= S_IDLE;
          case (cur_r.op)
            mts_pkg::OP_ATTACH: begin
              if (!was) begin
                wr_en_r      <= 1'b1;
                wr_addr_r    <= t_i;
                wr_data_r    <= {cnt_r + CW'(cur_r.dly), cur_r.dly};
                wrt_r[t_i]   <= 1'b1;
                active_r[t_i] <= 1'b1;
                rep_r[t_i]   <= cur_r.per;
                out_rem_r    <= 16'(CW'(cur_r.dly));
              end
            end
            mts_pkg::OP_DETACH: begin
              active_r[t_i] <= 1'b0;
              out_rem_r     <= '0;
            end
            mts_pkg::OP_CHANGE: begin
              wr_en_r    <= 1'b1;
              wr_addr_r  <= t_i;
              wrt_r[t_i] <= 1'b1;
              if (!was) begin
                wr_data_r <= {rd_tgt, cur_r.dly};
              end else begin
                wr_data_r   <= {chg_tgt, cur_r.dly};
                out_fired_r <= chg_fire;
                out_rem_r   <= 16'(chg_tgt - cnt_r);
              end
            end
            mts_pkg::OP_SYNC: begin
              if (!was && (cur_r.dly != 16'd0)) begin
                out_v_r <= 1'b0;
                state_r <= S_REF_RD;
              end
            end
            mts_pkg::OP_FIRE: begin
              out_fired_r <= 1'b1;
              if (rep_r[t_i]) begin
                wr_en_r       <= 1'b1;
                wr_addr_r     <= t_i;
                wr_data_r     <= {cnt_r + CW'(rd_dly), rd_dly};
                wrt_r[t_i]    <= 1'b1;
                active_r[t_i] <= 1'b1;
                out_rem_r     <= 16'(CW'(rd_dly));
              end else begin
                active_r[t_i] <= 1'b0;
                out_rem_r     <= '0;
              end
            end
            default: ;
          endcase
        end
        S_REF_RD: state_r <= S_REF_EV;
        S_REF_EV: begin
          // phase of the reference: counter minus its start point
          div_dvd_r <= cnt_r - (rd_tgt - CW'(rd_dly));
          div_rem_r <= '0;
          div_cnt_r <= DCW'(CW);
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (trial >= {1'b0, cur_r.dly}) begin
            div_rem_r <= 16'(trial - {1'b0, cur_r.dly});
          end else begin
            div_rem_r <= trial[15:0];
          end
          div_dvd_r <= div_dvd_r << 1;
          div_cnt_r <= div_cnt_r - DCW'(1);
          if (div_cnt_r == DCW'(1)) begin
            state_r <= S_SYNC_WR;
          end
        end
        S_SYNC_WR: begin
          wr_en_r       <= 1'b1;
          wr_addr_r     <= t_i;
          wr_data_r     <= {cnt_r + CW'(incr), cur_r.dly};
          wrt_r[t_i]    <= 1'b1;
          active_r[t_i] <= 1'b1;
          rep_r[t_i]    <= cur_r.per;
          out_v_r       <= 1'b1;
          out_fired_r   <= 1'b0;
          out_idx_r     <= cur_r.tidx;
          out_rem_r     <= 16'(CW'(incr));
          out_was_r     <= 1'b0;
          out_last_r    <= 1'b1;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe      = out_v_r;
  assign out_fired       = out_fired_r;
  assign out_fired_index = out_idx_r;
  assign out_remaining   = out_rem_r;
  assign out_was_running = out_was_r;
  assign out_last        = out_last_r;

endmodule

[hw/rtl/multi_timer_scheduler.sv]
// Virtual timer array: NUM_TIMERS timers share one wrapping counter of
// COUNTER_BITS bits. A word is taken when start is high and busy is low; a
// two-word queue sits between the decoder and the execution sequencer, so
// busy only rises when both queue slots are taken. Every result appears on
// the out_ ports for one cycle with out_strobe high and must be taken then;
// out_last marks the final result of a word. Attach in sync runs a
// remainder unit that takes one bit per cycle; a tick scans the slot
// memory one slot at a time and repeats the scan after each fire, with at
// most 64 fires per tick.
module multi_timer_scheduler #(
  parameter int NUM_TIMERS   = 8,
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [2:0]  in_timer_index,
  input  logic [2:0]  in_reference_index,
  input  logic [15:0] in_delay,
  input  logic        in_periodic,
  input  logic [15:0] in_advance,
  output logic        out_strobe,
  output logic        out_fired,
  output logic [2:0]  out_fired_index,
  output logic [15:0] out_remaining,
  output logic        out_was_running,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]    jitter_r;
  logic           q_valid;
  logic           pop;
  mts_pkg::word_t q_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jitter_r <= mts_pkg::JITTER_RESET;
    end else if (cfg_we) begin
      jitter_r <= cfg_wdata;
    end
  end

  mts_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_timer_index     (in_timer_index),
    .in_reference_index (in_reference_index),
    .in_delay           (in_delay),
    .in_periodic        (in_periodic),
    .in_advance         (in_advance),
    .pop                (pop),
    .q_valid            (q_valid),
    .q_word             (q_word)
  );

  mts_back #(.NUM_TIMERS(NUM_TIMERS), .COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .jitter          (jitter_r),
    .q_valid         (q_valid),
    .q_word          (q_word),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_fired       (out_fired),
    .out_fired_index (out_fired_index),
    .out_remaining   (out_remaining),
    .out_was_running (out_was_running),
    .out_last        (out_last)
  );

endmodule

[hw/rtl/mts_checker.sv]
module mts_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_fired,
  input logic out_was_running,
  input logic out_last
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  // only a chain of tick fires produces non-final results
  a_nonlast_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> out_fired && out_was_running)
    else $error("non-final result that is not a fire");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

endmodule

bind multi_timer_scheduler mts_checker u_mts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_fired       (out_fired),
  .out_was_running (out_was_running),
  .out_last        (out_last)
);

[test/tb_multi_timer_scheduler.sv]
module tb_multi_timer_scheduler;

  localparam logic [2:0] MODE_SPARE = 3'd7;
  localparam int NSLOT = 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [2:0]  mode;
    logic [2:0]  tidx;
    logic [2:0]  ridx;
    logic [15:0] dly;
    logic        per;
    logic [15:0] adv;
  } op_word_t;

  typedef struct {
    logic        fired;
    logic [2:0]  idx;
    logic [15:0] rem;
    logic        was;
    logic        last;
  } timer_event_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [2:0]  in_timer_index = '0;
  logic [2:0]  in_reference_index = '0;
  logic [15:0] in_delay = '0;
  logic        in_periodic = 0;
  logic [15:0] in_advance = '0;
  logic        out_strobe;
  logic        out_fired;
  logic [2:0]  out_fired_index;
  logic [15:0] out_remaining;
  logic        out_was_running;
  logic        out_last;
  logic        cfg_we = 0;
  logic [15:0] cfg_wdata = '0;

  op_word_t     pending_ops[$];
  timer_event_t expected_events[$];
  int           errors = 0;

  // shadow copy of the timer array
  logic [15:0] sh_jitter;
  logic [15:0] sh_count;
  logic [15:0] sh_target[NSLOT];
  logic [15:0] sh_delay[NSLOT];
  logic        sh_repeat[NSLOT];
  logic        sh_active[NSLOT];

  multi_timer_scheduler u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_timer_index(in_timer_index),
    .in_reference_index(in_reference_index), .in_delay(in_delay),
    .in_periodic(in_periodic), .in_advance(in_advance),
    .out_strobe(out_strobe), .out_fired(out_fired),
    .out_fired_index(out_fired_index), .out_remaining(out_remaining),
    .out_was_running(out_was_running), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] ticks_left(int s);
    return sh_active[s] ? 16'(sh_target[s] - sh_count) : 16'd0;
  endfunction

  function automatic void add_event(logic f, logic [2:0] i, logic [15:0] r, logic w,
                                    logic l);
    timer_event_t e;
    e.fired = f; e.idx = i; e.rem = r; e.was = w; e.last = l;
    expected_events.push_back(e);
  endfunction

  function automatic void predict_timers(op_word_t w);
    int          n;
    int          best;
    logic [15:0] late, best_late, elapsed, base, diff, incr;
    logic        f, was;
    int          t;
    n = 0;
    f = 1'b0;
    t = int'(w.tidx);
    if (w.mode == mts_pkg::MODE_TICK) begin
      sh_count = sh_count + w.adv;
      while (n < mts_pkg::FIRE_CAP) begin
        best = -1;
        best_late = '0;
        for (int s = 0; s < NSLOT; s++) begin
          if (sh_active[s]) begin
            late = sh_count - sh_target[s];
            if (late < sh_jitter && (best < 0 || late > best_late)) begin
              best = s;
              best_late = late;
            end
          end
        end
        if (best < 0) break;
        if (sh_repeat[best]) sh_target[best] = sh_target[best] + sh_delay[best];
        else sh_active[best] = 1'b0;
        add_event(1'b1, best[2:0], ticks_left(best), 1'b1, 1'b0);
        n++;
      end
      if (n == 0) add_event(1'b0, 3'd0, 16'd0, 1'b0, 1'b1);
      else expected_events[$].last = 1'b1;
      return;
    end
    was = sh_active[t];
    case (w.mode)
      mts_pkg::MODE_ATTACH: if (!was) begin
        sh_delay[t] = w.dly;
        sh_repeat[t] = w.per;
        sh_target[t] = sh_count + w.dly;
        sh_active[t] = 1'b1;
      end
      mts_pkg::MODE_DETACH: sh_active[t] = 1'b0;
      mts_pkg::MODE_CHANGE: begin
        if (was) begin
          elapsed = sh_delay[t] - ticks_left(t);
          if (elapsed > w.dly) begin
            f = 1'b1;
            sh_target[t] = sh_count + w.dly;
          end else begin
            sh_target[t] = sh_target[t] + w.dly - sh_delay[t];
          end
        end
        sh_delay[t] = w.dly;
      end
      mts_pkg::MODE_SYNC: if (!was && w.dly != 0) begin
        base = sh_target[w.ridx] - sh_delay[w.ridx];
        diff = sh_count - base;
        incr = w.dly - (diff % w.dly);
        sh_delay[t] = w.dly;
        sh_repeat[t] = w.per;
        sh_target[t] = sh_count + incr;
        sh_active[t] = 1'b1;
      end
      mts_pkg::MODE_FIRE: begin
        f = 1'b1;
        if (sh_repeat[t]) begin
          sh_target[t] = sh_count + sh_delay[t];
          sh_active[t] = 1'b1;
        end else begin
          sh_active[t] = 1'b0;
        end
      end
      default: ;
    endcase
    add_event(f, w.tidx, ticks_left(t), was, 1'b1);
  endfunction

  // driver: one word in flight on the start/busy handshake
  int gap_cnt = 0;
  always @(posedge clk) begin
    logic     go;
    op_word_t w;
    go = start;
    if (rst_n) begin
      if (start && !busy) begin
        w.mode = in_mode; w.tidx = in_timer_index; w.ridx = in_reference_index;
        w.dly = in_delay; w.per = in_periodic; w.adv = in_advance;
        predict_timers(w);
        go = 1'b0;
        gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 7));
      end
      if (!go) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pending_ops.size() > 0) begin
          w = pending_ops.pop_front();
          in_mode <= w.mode;
          in_timer_index <= w.tidx;
          in_reference_index <= w.ridx;
          in_delay <= w.dly;
          in_periodic <= w.per;
          in_advance <= w.adv;
          go = 1'b1;
        end
      end
    end
    start <= go;
  end

  // monitor
  always @(posedge clk) begin
    timer_event_t e;
    if (rst_n && out_strobe) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result word, index %0d", out_fired_index);
        errors++;
      end else begin
        e = expected_events.pop_front();
        if (out_fired !== e.fired) begin
          $error("fired: expected %0d actual %0d", e.fired, out_fired); errors++;
        end
        if (out_fired_index !== e.idx) begin
          $error("fired_index: expected %0d actual %0d", e.idx, out_fired_index); errors++;
        end
        if (out_remaining !== e.rem) begin
          $error("remaining: expected %0d actual %0d", e.rem, out_remaining); errors++;
        end
        if (out_was_running !== e.was) begin
          $error("was_running: expected %0d actual %0d", e.was, out_was_running); errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  // watchdog on stalls while work is outstanding
  int stall_cnt = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe ||
        (pending_ops.size() == 0 && expected_events.size() == 0 && !start)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic void queue_op(logic [2:0] m, logic [2:0] t, logic [2:0] r,
                                   logic [15:0] d, logic p, logic [15:0] a);
    op_word_t w;
    w.mode = m; w.tidx = t; w.ridx = r; w.dly = d; w.per = p; w.adv = a;
    pending_ops.push_back(w);
  endfunction

  function automatic void queue_random_op();
    op_word_t w;
    int       pick;
    w.mode = 3'($urandom_range(0, 7));
    w.tidx = 3'($urandom_range(0, 7));
    w.ridx = 3'($urandom_range(0, 7));
    w.dly = 16'($urandom);
    w.per = 1'($urandom_range(0, 1));
    w.adv = 16'($urandom);
    pick = int'($urandom_range(0, 99));
    // mostly small delays and advances so timers actually come due
    if (pick < 40) begin
      w.mode = mts_pkg::MODE_TICK;
      if ($urandom_range(0, 9) != 0) w.adv = 16'($urandom_range(0, 60));
    end else if (pick < 65) begin
      w.mode = ($urandom_range(0, 3) == 0) ? mts_pkg::MODE_SYNC : mts_pkg::MODE_ATTACH;
      if ($urandom_range(0, 9) != 0) w.dly = 16'($urandom_range(0, 80));
    end else if (pick < 75) begin
      w.mode = mts_pkg::MODE_CHANGE;
      if ($urandom_range(0, 9) != 0) w.dly = 16'($urandom_range(0, 80));
    end else if (pick < 95 && w.mode == MODE_SPARE && $urandom_range(0, 1) != 0) begin
      w.mode = mts_pkg::MODE_QUERY;
    end
    pending_ops.push_back(w);
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() > 0 || start || expected_events.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_jitter(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_jitter = v;
  endtask

  initial begin
    logic [15:0] windows[5];
    windows = '{16'd1000, 16'd1, 16'd65535, 16'd37, 16'd1000};
    sh_jitter = mts_pkg::JITTER_RESET;
    sh_count = '0;
    for (int s = 0; s < NSLOT; s++) begin
      sh_target[s] = '0; sh_delay[s] = '0; sh_repeat[s] = 1'b0; sh_active[s] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed words first
    queue_op(mts_pkg::MODE_QUERY, 3'd7, 3'd0, 16'd0, 1'b0, 16'd0);
    queue_op(mts_pkg::MODE_TICK, 3'd0, 3'd0, 16'd0, 1'b0, 16'd0);
    queue_op(mts_pkg::MODE_ATTACH, 3'd0, 3'd0, 16'd10, 1'b1, 16'd0);
    queue_op(mts_pkg::MODE_ATTACH, 3'd1, 3'd0, 16'd10, 1'b0, 16'd0);
    queue_op(mts_pkg::MODE_ATTACH, 3'd0, 3'd0, 16'd99, 1'b0, 16'd0);   // running, no change
    queue_op(mts_pkg::MODE_TICK, 3'd0, 3'd0, 16'd0, 1'b0, 16'd10);     // tie, lowest index
    queue_op(mts_pkg::MODE_DETACH, 3'd1, 3'd0, 16'd0, 1'b0, 16'd0);    // already stopped
    queue_op(mts_pkg::MODE_CHANGE, 3'd2, 3'd0, 16'd50, 1'b0, 16'd0);   // stopped slot
    queue_op(mts_pkg::MODE_TICK, 3'd0, 3'd0, 16'd0, 1'b0, 16'd7);
    queue_op(mts_pkg::MODE_CHANGE, 3'd0, 3'd0, 16'd3, 1'b0, 16'd0);    // already elapsed
    queue_op(mts_pkg::MODE_CHANGE, 3'd0, 3'd0, 16'd20, 1'b0, 16'd0);
    queue_op(mts_pkg::MODE_SYNC, 3'd3, 3'd0, 16'd0, 1'b1, 16'd0);      // zero delay ignored
    queue_op(mts_pkg::MODE_SYNC, 3'd3, 3'd0, 16'd6, 1'b1, 16'd0);
    queue_op(mts_pkg::MODE_SYNC, 3'd4, 3'd5, 16'd65535, 1'b0, 16'd0);  // stopped reference
    queue_op(mts_pkg::MODE_FIRE, 3'd3, 3'd0, 16'd0, 1'b0, 16'd0);
    queue_op(mts_pkg::MODE_FIRE, 3'd4, 3'd0, 16'd0, 1'b0, 16'd0);
    queue_op(MODE_SPARE, 3'd0, 3'd7, 16'hffff, 1'b1, 16'hffff);
    queue_op(mts_pkg::MODE_DETACH, 3'd0, 3'd0, 16'd0, 1'b0, 16'd0);
    queue_op(mts_pkg::MODE_DETACH, 3'd3, 3'd0, 16'd0, 1'b0, 16'd0);
    queue_op(mts_pkg::MODE_ATTACH, 3'd6, 3'd0, 16'd0, 1'b1, 16'd0);    // re-arms in place
    queue_op(mts_pkg::MODE_TICK, 3'd0, 3'd0, 16'd0, 1'b0, 16'd0);      // hits the fire cap
    queue_op(mts_pkg::MODE_DETACH, 3'd6, 3'd0, 16'd0, 1'b0, 16'd0);
    queue_op(mts_pkg::MODE_TICK, 3'd0, 3'd0, 16'd0, 1'b0, 16'd65535);
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_jitter(windows[ph]);
      for (int k = 0; k < 88; k++) queue_random_op();
    end
    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
